[rtl/http_request_line_parser_unit_assert.svh]
// Assertion macros used by the request line parser back end.
`ifndef HTTP_REQUEST_LINE_PARSER_UNIT_ASSERT_SVH
`define HTTP_REQUEST_LINE_PARSER_UNIT_ASSERT_SVH
// The consequent must hold at the same clock edge as the antecedent.
`define HRLP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold at the clock edge after the antecedent.
`define HRLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/hrlp_pkg.sv]
// Types, constants and helper functions of the request line parser.
`default_nettype none

package hrlp_pkg;

    localparam int MAX_LINE    = 4096;
    localparam int OFS_W       = 13;
    localparam int STATUS_W    = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OFS_W-1:0] MAX_OFS = OFS_W'(MAX_LINE);

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum logic [3:0] {
        PH_SKIP,
        PH_METHOD,
        PH_WS1,
        PH_TARGET,
        PH_WS2,
        PH_VERSION,
        PH_WS3,
        PH_DONE,
        PH_BAD
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_VALID         = 3'd0,
        ST_EMPTY         = 3'd1,
        ST_AFTER_METHOD  = 3'd2,
        ST_AFTER_TARGET  = 3'd3,
        ST_AFTER_VERSION = 3'd4,
        ST_MISSING_LF    = 3'd5
    } status_t;

    typedef struct packed {
        logic ws;
        logic lf;
        logic crlf;
        logic eob;
    } byte_class_t;

    typedef struct packed {
        status_t          status;
        logic [OFS_W-1:0] method_start;
        logic [OFS_W-1:0] method_length;
        logic [OFS_W-1:0] target_start;
        logic [OFS_W-1:0] target_length;
        logic [OFS_W-1:0] version_start;
        logic [OFS_W-1:0] version_length;
        logic [OFS_W-1:0] line_end;
        logic             overflow;
    } result_t;

    function automatic logic [OFS_W-1:0] sat_inc(input logic [OFS_W-1:0] v);
        return (v < MAX_OFS) ? v + OFS_W'(1) : MAX_OFS;
    endfunction

endpackage

`default_nettype wire

[rtl/hrlp_if.sv]
// Byte stream and result channel interfaces of the request line parser.
`default_nettype none

interface hrlp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface hrlp_result_if;
    import hrlp_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [OFS_W-1:0]    method_start;
    logic [OFS_W-1:0]    method_length;
    logic [OFS_W-1:0]    target_start;
    logic [OFS_W-1:0]    target_length;
    logic [OFS_W-1:0]    version_start;
    logic [OFS_W-1:0]    version_length;
    logic [OFS_W-1:0]    line_end;
    logic                overflow;

    modport source (
        output valid, output status, output method_start, output method_length,
        output target_start, output target_length, output version_start,
        output version_length, output line_end, output overflow, input ready
    );
    modport sink (
        input valid, input status, input method_start, input method_length,
        input target_start, input target_length, input version_start,
        input version_length, input line_end, input overflow, output ready
    );
endinterface

`default_nettype wire

[rtl/hrlp_front.sv]
// Front end: accepts raw bytes and classifies them for the tokenizer.
`default_nettype none

module hrlp_front (
    hrlp_byte_if.sink          stream,
    output logic               push_valid,
    input  logic               push_ready,
    output hrlp_pkg::byte_class_t push_entry
);
    import hrlp_pkg::*;

    logic [7:0] b;

    assign b            = stream.data_byte;
    assign stream.ready = push_ready;
    assign push_valid   = stream.valid;

    always_comb
    begin
        push_entry.ws   = (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR) ||
                          (b == CHAR_VT) || (b == CHAR_FF);
        push_entry.lf   = (b == CHAR_LF);
        push_entry.crlf = (b == CHAR_CR) || (b == CHAR_LF);
        push_entry.eob  = stream.end_of_buffer;
    end

endmodule

`default_nettype wire

[rtl/hrlp_queue.sv]
// Short queue of classified bytes between the front end and the tokenizer.
`default_nettype none

module hrlp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  hrlp_pkg::byte_class_t push_entry,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output hrlp_pkg::byte_class_t pop_entry
);
    import hrlp_pkg::*;

    byte_class_t       slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

[rtl/hrlp_back.sv]
// Back end: tokenizer state machine and registered result output.
`default_nettype none
`include "http_request_line_parser_unit_assert.svh"

module hrlp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  hrlp_pkg::byte_class_t pop_entry,
    hrlp_result_if.source         result
);
    import hrlp_pkg::*;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [OFS_W-1:0] position_reg;
    logic [OFS_W-1:0] position_next;
    logic [OFS_W-1:0] method_begin_reg;
    logic [OFS_W-1:0] method_begin_next;
    logic [OFS_W-1:0] method_count_reg;
    logic [OFS_W-1:0] method_count_next;
    logic [OFS_W-1:0] target_begin_reg;
    logic [OFS_W-1:0] target_begin_next;
    logic [OFS_W-1:0] target_count_reg;
    logic [OFS_W-1:0] target_count_next;
    logic [OFS_W-1:0] version_begin_reg;
    logic [OFS_W-1:0] version_begin_next;
    logic [OFS_W-1:0] version_count_reg;
    logic [OFS_W-1:0] version_count_next;
    logic             saturated_reg;
    logic             saturated_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_data_reg;
    result_t          out_data_next;
    logic             take;
    logic             sat;
    logic             hit_lf;
    logic             emit;

    function automatic status_t status_of(input phase_t ph);
        case (ph)
            PH_SKIP:               return ST_EMPTY;
            PH_METHOD, PH_WS1:     return ST_AFTER_METHOD;
            PH_TARGET, PH_WS2:     return ST_AFTER_TARGET;
            PH_VERSION, PH_WS3:    return ST_AFTER_VERSION;
            default:               return ST_MISSING_LF;
        endcase
    endfunction

    assign pop_ready = !out_valid_reg || result.ready;
    assign take      = pop_valid && pop_ready;

    always_comb
    begin
        phase_next         = phase_reg;
        position_next      = position_reg;
        method_begin_next  = method_begin_reg;
        method_count_next  = method_count_reg;
        target_begin_next  = target_begin_reg;
        target_count_next  = target_count_reg;
        version_begin_next = version_begin_reg;
        version_count_next = version_count_reg;
        saturated_next     = saturated_reg;
        out_valid_next     = out_valid_reg && !result.ready;
        out_data_next      = out_data_reg;
        sat                = saturated_reg || (position_reg >= MAX_OFS);
        hit_lf             = 1'b0;
        emit               = 1'b0;

        if (take)
        begin
            saturated_next = sat;
            case (phase_reg)
                PH_SKIP:
                begin
                    if (!pop_entry.crlf)
                    begin
                        method_begin_next = position_reg;
                        if (pop_entry.ws)
                        begin
                            phase_next = PH_WS1;
                        end
                        else
                        begin
                            method_count_next = OFS_W'(1);
                            phase_next        = PH_METHOD;
                        end
                    end
                end
                PH_METHOD:
                begin
                    if (pop_entry.ws)
                    begin
                        phase_next = PH_WS1;
                    end
                    else
                    begin
                        method_count_next = sat_inc(method_count_reg);
                    end
                end
                PH_WS1:
                begin
                    if (!pop_entry.ws)
                    begin
                        target_begin_next = position_reg;
                        target_count_next = OFS_W'(1);
                        phase_next        = PH_TARGET;
                    end
                end
                PH_TARGET:
                begin
                    if (pop_entry.ws)
                    begin
                        phase_next = PH_WS2;
                    end
                    else
                    begin
                        target_count_next = sat_inc(target_count_reg);
                    end
                end
                PH_WS2:
                begin
                    if (!pop_entry.ws)
                    begin
                        version_begin_next = position_reg;
                        version_count_next = OFS_W'(1);
                        phase_next         = PH_VERSION;
                    end
                end
                PH_VERSION:
                begin
                    if (pop_entry.ws)
                    begin
                        phase_next = PH_WS3;
                    end
                    else
                    begin
                        version_count_next = sat_inc(version_count_reg);
                    end
                end
                PH_WS3:
                begin
                    if (!pop_entry.ws)
                    begin
                        if (pop_entry.lf)
                        begin
                            hit_lf     = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_BAD;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            position_next = sat_inc(position_reg);
            emit = hit_lf || (pop_entry.eob && (phase_reg != PH_DONE));

            if (emit)
            begin
                out_valid_next               = 1'b1;
                out_data_next.status         = hit_lf ? ST_VALID : status_of(phase_next);
                out_data_next.method_start   = method_begin_next;
                out_data_next.method_length  = method_count_next;
                out_data_next.target_start   = target_begin_next;
                out_data_next.target_length  = target_count_next;
                out_data_next.version_start  = version_begin_next;
                out_data_next.version_length = version_count_next;
                out_data_next.line_end       = position_next;
                out_data_next.overflow       = sat;
            end

            if (pop_entry.eob)
            begin
                phase_next         = PH_SKIP;
                position_next      = '0;
                method_begin_next  = '0;
                method_count_next  = '0;
                target_begin_next  = '0;
                target_count_next  = '0;
                version_begin_next = '0;
                version_count_next = '0;
                saturated_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_SKIP;
            position_reg      <= '0;
            method_begin_reg  <= '0;
            method_count_reg  <= '0;
            target_begin_reg  <= '0;
            target_count_reg  <= '0;
            version_begin_reg <= '0;
            version_count_reg <= '0;
            saturated_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            position_reg      <= position_next;
            method_begin_reg  <= method_begin_next;
            method_count_reg  <= method_count_next;
            target_begin_reg  <= target_begin_next;
            target_count_reg  <= target_count_next;
            version_begin_reg <= version_begin_next;
            version_count_reg <= version_count_next;
            saturated_reg     <= saturated_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = out_data_reg.status;
    assign result.method_start   = out_data_reg.method_start;
    assign result.method_length  = out_data_reg.method_length;
    assign result.target_start   = out_data_reg.target_start;
    assign result.target_length  = out_data_reg.target_length;
    assign result.version_start  = out_data_reg.version_start;
    assign result.version_length = out_data_reg.version_length;
    assign result.line_end       = out_data_reg.line_end;
    assign result.overflow       = out_data_reg.overflow;

    `HRLP_ASSERT_NEXT(a_rearm_after_end, take && pop_entry.eob, (phase_reg == PH_SKIP) && (position_reg == '0), "state not rearmed after end of buffer")
    `HRLP_ASSERT_NOW(a_sat_position, saturated_reg, position_reg == MAX_OFS, "overflow flagged below the line limit")
    `HRLP_ASSERT_NOW(a_method_phase, method_count_reg != '0, phase_reg != PH_SKIP, "method bytes counted while still skipping")
    `HRLP_ASSERT_NOW(a_valid_line_end, out_valid_reg && (out_data_reg.status == ST_VALID), out_data_reg.line_end != '0, "valid line reported with zero line end")

endmodule

`default_nettype wire

[rtl/http_request_line_parser_unit.sv]
// Top level of the HTTP request line parser: front end, byte queue and tokenizer.
// Throughput is one byte per clock while no result waits on the output; the tokenizer steps once per byte.
// With an empty queue the byte that ends a line goes into a queue slot, then the tokenizer and its output register.
// A result waiting on the output register stalls the tokenizer; the queue keeps taking input until it is full.
// Asynchronous active-low reset empties the queue and returns the tokenizer to skipping CR/LF.
`default_nettype none

module http_request_line_parser_unit (
    input  logic          clk,
    input  logic          rst_n,
    hrlp_byte_if.sink     stream,
    hrlp_result_if.source result
);
    import hrlp_pkg::*;

    logic        push_valid;
    logic        push_ready;
    byte_class_t push_entry;
    logic        pop_valid;
    logic        pop_ready;
    byte_class_t pop_entry;

    hrlp_front u_front (
        .stream     (stream),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    hrlp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    hrlp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .result    (result)
    );

endmodule

`default_nettype wire
